// ===== hdl/izn_pkg.sv =====
// Shared widths, register indexes and reset constants for the Izhikevich neuron update block.
package izn_pkg;

  localparam int IDX_W     = 7;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int NEURONS_DEF    = 128;
  localparam int RSP_FIFO_DEPTH = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUAD_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_VOLTAGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_VOLTAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_VOLTAGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_VOLTAGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENS   = 3'd7;

  localparam logic        [22:0] QUAD_GAIN_RST   = 23'd32768;
  localparam logic signed [23:0] REST_VOLT_RST   = -24'sd3932160;
  localparam logic signed [23:0] THRESH_VOLT_RST = -24'sd2949120;
  localparam logic signed [23:0] PEAK_VOLT_RST   = 24'sd2293760;
  localparam logic signed [23:0] RESET_VOLT_RST  = -24'sd2621440;
  localparam logic signed [23:0] REC_JUMP_RST    = 24'sd6553600;
  localparam logic        [16:0] REC_RATE_RST    = 17'd1311;
  localparam logic signed [23:0] REC_SENS_RST    = 24'sd32768;

  // Stored state after reset: -60 mV and zero recovery.
  localparam logic signed [DATA_W-1:0] VOLT_INIT = -32'sd3932160;
  localparam logic signed [DATA_W-1:0] REC_INIT  = 32'sd0;

  // Step over capacitance, 0.01 in Q0.24.
  localparam logic [17:0] STEP_GAIN = 18'd167772;

endpackage

// ===== hdl/izn_req_if.sv =====
// Request channel: one neuron update item with its currents.
interface izn_req_if import izn_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         neuron_index;
  logic signed [DATA_W-1:0] ext_current;
  logic signed [DATA_W-1:0] syn_current;

  modport source (output valid, output neuron_index, output ext_current,
                  output syn_current, input ready);
  modport sink   (input valid, input neuron_index, input ext_current,
                  input syn_current, output ready);

endinterface

// ===== hdl/izn_rsp_if.sv =====
// Result channel: updated voltage and recovery of one neuron.
interface izn_rsp_if import izn_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_index;
  logic                     spiked;
  logic signed [DATA_W-1:0] new_voltage;
  logic signed [DATA_W-1:0] new_recovery;

  modport source (output valid, output out_index, output spiked, output new_voltage,
                  output new_recovery, input ready);
  modport sink   (input valid, input out_index, input spiked, input new_voltage,
                  input new_recovery, output ready);

endinterface

// ===== hdl/izhikevich_neuron_update_top.sv =====
// Izhikevich neuron Euler update: state memories, eight-stage datapath and result FIFO.
//
//   channel      dir  handshake      payload
//   update_req   in   valid/ready    neuron_index, ext_current, syn_current
//   update_rsp   out  valid/ready    out_index, spiked, new_voltage, new_recovery
//   cfg          in   cfg_wr_en      cfg_index, cfg_wdata
//
// One item per cycle for distinct neurons, except during the stalls described below.
// An item for a neuron that is still in the eight-stage pipeline waits until that
// neuron's write-back, since the state memory is read at accept.
// After reset a clearing pass writes every state entry; no item is accepted during it.
// Items keep flowing while results wait; the 16-entry result FIFO throttles input
// only when 16 items are outstanding.
module izhikevich_neuron_update_top import izn_pkg::*; #(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  izn_req_if.sink              update_req,
  izn_rsp_if.source            update_rsp
);

  localparam int ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int NSTAGE  = 8;
  localparam int FIFO_AW = $clog2(RSP_FIFO_DEPTH);
  localparam int CNT_W   = FIFO_AW + 1;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     spike;
    logic signed [DATA_W-1:0] nv;
    logic signed [DATA_W-1:0] nu;
  } rsp_entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // Configuration registers.
  logic        [22:0] reg_k;
  logic signed [23:0] reg_vr, reg_vt, reg_vpeak, reg_c, reg_d, reg_b;
  logic        [16:0] reg_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_k     <= QUAD_GAIN_RST;
      reg_vr    <= REST_VOLT_RST;
      reg_vt    <= THRESH_VOLT_RST;
      reg_vpeak <= PEAK_VOLT_RST;
      reg_c     <= RESET_VOLT_RST;
      reg_d     <= REC_JUMP_RST;
      reg_a     <= REC_RATE_RST;
      reg_b     <= REC_SENS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_QUAD_GAIN:      reg_k     <= cfg_wdata[22:0];
        REG_REST_VOLTAGE:   reg_vr    <= cfg_wdata;
        REG_THRESH_VOLTAGE: reg_vt    <= cfg_wdata;
        REG_PEAK_VOLTAGE:   reg_vpeak <= cfg_wdata;
        REG_RESET_VOLTAGE:  reg_c     <= cfg_wdata;
        REG_RECOVERY_JUMP:  reg_d     <= cfg_wdata;
        REG_RECOVERY_RATE:  reg_a     <= cfg_wdata[16:0];
        REG_RECOVERY_SENS:  reg_b     <= cfg_wdata;
      endcase
    end
  end

  // Neuron index to memory address, folded modulo NEURONS by a constant table.
  logic [ADDR_W-1:0] idx_map [1<<IDX_W];
  for (genvar g = 0; g < (1 << IDX_W); g++) begin : g_idx_map
    assign idx_map[g] = ADDR_W'(g % NEURONS);
  end

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [NSTAGE-1:0] vld;
  logic [IDX_W-1:0]  idx_p  [NSTAGE];
  logic [ADDR_W-1:0] addr_p [NSTAGE];
  logic [CNT_W-1:0]  pending;
  logic [ADDR_W-1:0] req_addr;
  logic              hazard;
  logic              accept;
  logic              pop;
  logic              push;

  assign req_addr = idx_map[update_req.neuron_index];

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < NSTAGE; i++) begin
      if (vld[i] && (addr_p[i] == req_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  assign update_req.ready = !clearing && !hazard && (pending < CNT_W'(RSP_FIFO_DEPTH));
  assign accept = update_req.valid && update_req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(NEURONS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // State memories: one write port shared by the clearing pass and write-back.
  logic signed [DATA_W-1:0] volt_mem [NEURONS];
  logic signed [DATA_W-1:0] rec_mem  [NEURONS];
  logic signed [DATA_W-1:0] v_rd, u_rd;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wv, mem_wu;
  logic signed [DATA_W-1:0] nv_c;
  logic signed [DATA_W-1:0] nu8;

  assign mem_we    = clearing || vld[NSTAGE-1];
  assign mem_waddr = clearing ? clr_addr : addr_p[NSTAGE-1];
  assign mem_wv    = clearing ? VOLT_INIT : nv_c;
  assign mem_wu    = clearing ? REC_INIT : nu8;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      volt_mem[mem_waddr] <= mem_wv;
      rec_mem[mem_waddr]  <= mem_wu;
    end
    v_rd <= volt_mem[req_addr];
    u_rd <= rec_mem[req_addr];
  end

  // Datapath registers, named by the stage that consumes them.
  logic signed [DATA_W-1:0] iext1, isyn1;
  logic signed [31:0] dv2, dt2, v2, u2;
  logic signed [32:0] isum2, isum3, isum4, isum5;
  logic               spike2, spike3, spike4, spike5, spike6, spike7, spike8;
  logic signed [63:0] p1_3;
  logic signed [55:0] pb3;
  logic signed [31:0] v3, u3, q4, v4, u4, v5, u5, v6, u6, v7, v8, nu7;
  logic signed [40:0] r4;
  logic signed [55:0] qk5;
  logic signed [42:0] rha5;
  logic        [32:0] rla5;
  logic signed [41:0] sum6;
  logic signed [59:0] ra6;
  logic signed [39:0] shg7;
  logic        [38:0] slg7;
  logic signed [60:0] prod8;

  logic signed [31:0] dv_c, dt_c, q_c, nu_c;
  logic               spike_c;
  logic signed [32:0] isum_c;
  logic signed [63:0] p1_c;
  logic signed [55:0] pb_c, qk_c;
  logic signed [40:0] r_c;
  logic signed [42:0] rha_c;
  logic        [32:0] rla_c;
  logic signed [41:0] sum_c;
  logic signed [59:0] ra_c;
  logic signed [39:0] shg_c;
  logic        [38:0] slg_c;
  logic signed [60:0] prod_c;

  // Stage 1: differences against rest and threshold, spike test, current sum.
  assign dv_c    = sat32(64'(v_rd) - 64'(reg_vr));
  assign dt_c    = sat32(64'(v_rd) - 64'(reg_vt));
  assign spike_c = v_rd > 32'(reg_vpeak);
  assign isum_c  = 33'(iext1) + 33'(isyn1);

  // Stage 2: the two products of the voltage difference.
  assign p1_c = dv2 * dt2;
  assign pb_c = dv2 * reg_b;

  // Stage 3: quadratic term saturated, recovery drive.
  assign q_c = sat32(p1_3 >>> 16);
  assign r_c = 41'(pb3 >>> 16) - 41'(u3);

  // Stage 4: gain multiply; the rate multiply is split at bit 16 of r.
  assign qk_c  = q4 * $signed({1'b0, reg_k});
  assign rha_c = $signed(r4[40:16]) * $signed({1'b0, reg_a});
  assign rla_c = r4[15:0] * reg_a;

  // Stage 5: membrane sum and recombined recovery product.
  assign sum_c = 42'(qk5 >>> 16) - 42'(u5) + 42'(isum5);
  assign ra_c  = ($signed({{17{rha5[42]}}, rha5}) <<< 16) + $signed({27'd0, rla5});

  // Stage 6: step gain split at bit 21 of the sum; new recovery.
  assign shg_c = $signed(sum6[41:21]) * $signed({1'b0, STEP_GAIN});
  assign slg_c = sum6[20:0] * STEP_GAIN;
  assign nu_c  = spike6 ? sat32(64'(u6) + 64'(reg_d)) : sat32(64'(u6) + 64'(ra6 >>> 17));

  // Stage 7: recombine the step product.
  assign prod_c = ($signed({{21{shg7[39]}}, shg7}) <<< 21) + $signed({22'd0, slg7});

  // Stage 8: new voltage, written back and queued.
  assign nv_c = spike8 ? 32'(reg_c) : sat32(64'(v8) + 64'(prod8 >>> 24));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    idx_p[0]  <= update_req.neuron_index;
    addr_p[0] <= req_addr;
    for (int i = 1; i < NSTAGE; i++) begin
      idx_p[i]  <= idx_p[i-1];
      addr_p[i] <= addr_p[i-1];
    end
    iext1  <= update_req.ext_current;
    isyn1  <= update_req.syn_current;
    dv2    <= dv_c;
    dt2    <= dt_c;
    v2     <= v_rd;
    u2     <= u_rd;
    spike2 <= spike_c;
    isum2  <= isum_c;
    p1_3   <= p1_c;
    pb3    <= pb_c;
    v3     <= v2;
    u3     <= u2;
    spike3 <= spike2;
    isum3  <= isum2;
    q4     <= q_c;
    r4     <= r_c;
    v4     <= v3;
    u4     <= u3;
    spike4 <= spike3;
    isum4  <= isum3;
    qk5    <= qk_c;
    rha5   <= rha_c;
    rla5   <= rla_c;
    v5     <= v4;
    u5     <= u4;
    spike5 <= spike4;
    isum5  <= isum4;
    sum6   <= sum_c;
    ra6    <= ra_c;
    v6     <= v5;
    u6     <= u5;
    spike6 <= spike5;
    shg7   <= shg_c;
    slg7   <= slg_c;
    nu7    <= nu_c;
    v7     <= v6;
    spike7 <= spike6;
    prod8  <= prod_c;
    nu8    <= nu7;
    v8     <= v7;
    spike8 <= spike7;
  end

  // Result FIFO.
  rsp_entry_t         fifo_mem [RSP_FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fifo_cnt;
  rsp_entry_t         head;

  assign push = vld[NSTAGE-1];
  assign pop  = update_rsp.valid && update_rsp.ready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{idx: idx_p[NSTAGE-1], spike: spike8, nv: nv_c, nu: nu8};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fifo_cnt <= fifo_cnt + 1'b1;
        2'b01:   fifo_cnt <= fifo_cnt - 1'b1;
        default: fifo_cnt <= fifo_cnt;
      endcase
      case ({accept, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  assign update_rsp.valid        = fifo_cnt != '0;
  assign update_rsp.out_index    = head.idx;
  assign update_rsp.spiked       = head.spike;
  assign update_rsp.new_voltage  = head.nv;
  assign update_rsp.new_recovery = head.nu;

  // Every outstanding item is either in the pipeline or in the FIFO.
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    pending == fifo_cnt + CNT_W'($countones(vld)))
    else $error("outstanding item count disagrees with pipeline and FIFO");

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_cnt != CNT_W'(RSP_FIFO_DEPTH)) || pop)
    else $error("result FIFO overflow");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (vld == '0) && (pending == '0))
    else $error("item in flight during clearing pass");

  a_no_stale_read: assert property (@(posedge clk) disable iff (rst)
    accept && vld[NSTAGE-1] |-> addr_p[NSTAGE-1] != req_addr)
    else $error("read of an entry whose write-back lands at the same edge");

endmodule

// ===== tb/izhikevich_neuron_update_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Izhikevich neuron update block.
module izhikevich_neuron_update_top_tb import izn_pkg::*; ();

  localparam longint STEP_Q24     = STEP_GAIN;
  localparam longint SAT_MAX      = 64'sd2147483647;
  localparam longint SAT_MIN      = -64'sd2147483648;
  localparam longint RUN_LIMIT_NS = 5_000_000;
  localparam int     MV           = 65536;
  localparam logic signed [DATA_W-1:0] I_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] I_MIN = 32'sh8000_0000;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic                     spiked;
    logic signed [DATA_W-1:0] voltage;
    logic signed [DATA_W-1:0] recovery;
  } neuron_update_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  izn_req_if update_req ();
  izn_rsp_if update_rsp ();

  izhikevich_neuron_update_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .update_req (update_req),
    .update_rsp (update_rsp)
  );

  // Parameters and per-neuron state as the block should hold them.
  longint quad_gain, rest_v, thresh_v, peak_v, reset_v, rec_jump, rec_rate, rec_sens;
  int     volt_mem [NEURONS_DEF];
  int     rec_mem  [NEURONS_DEF];

  neuron_update_t expected_updates[$];
  int mismatch_count = 0;
  int send_calm      = 0;
  int recv_calm      = 0;

  always #5 clk = ~clk;

  function automatic longint clamp32(longint x);
    if (x > SAT_MAX) return SAT_MAX;
    if (x < SAT_MIN) return SAT_MIN;
    return x;
  endfunction

  // One Euler step of one neuron; updates the stored state and returns the result.
  function automatic neuron_update_t euler_step(logic [IDX_W-1:0] idx,
                                                logic signed [DATA_W-1:0] i_ext,
                                                logic signed [DATA_W-1:0] i_syn);
    neuron_update_t res;
    longint v, u, dv, dt, q, quad, total, r, nv, nu;
    v = volt_mem[idx];
    u = rec_mem[idx];
    res.spiked = (v > peak_v);
    if (res.spiked) begin
      nv = reset_v;
      nu = clamp32(u + rec_jump);
    end else begin
      dv    = clamp32(v - rest_v);
      dt    = clamp32(v - thresh_v);
      q     = clamp32((dv * dt) >>> 16);
      quad  = (q * quad_gain) >>> 16;
      total = quad - u + longint'(i_ext) + longint'(i_syn);
      nv    = clamp32(v + ((total * STEP_Q24) >>> 24));
      r     = ((dv * rec_sens) >>> 16) - u;
      nu    = clamp32(u + ((r * rec_rate) >>> 17));
    end
    volt_mem[idx] = int'(nv);
    rec_mem[idx]  = int'(nu);
    res.index    = idx;
    res.voltage  = nv[DATA_W-1:0];
    res.recovery = nu[DATA_W-1:0];
    return res;
  endfunction

  // Random gap before the next item or ready; occasionally starts a calm stretch of zero gaps.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic reset_model();
    quad_gain = QUAD_GAIN_RST;
    rest_v    = REST_VOLT_RST;
    thresh_v  = THRESH_VOLT_RST;
    peak_v    = PEAK_VOLT_RST;
    reset_v   = RESET_VOLT_RST;
    rec_jump  = REC_JUMP_RST;
    rec_rate  = REC_RATE_RST;
    rec_sens  = REC_SENS_RST;
    foreach (volt_mem[i]) begin
      volt_mem[i] = VOLT_INIT;
      rec_mem[i]  = REC_INIT;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    case (idx)
      REG_QUAD_GAIN:      quad_gain = longint'(value[22:0]);
      REG_REST_VOLTAGE:   rest_v    = longint'($signed(value[23:0]));
      REG_THRESH_VOLTAGE: thresh_v  = longint'($signed(value[23:0]));
      REG_PEAK_VOLTAGE:   peak_v    = longint'($signed(value[23:0]));
      REG_RESET_VOLTAGE:  reset_v   = longint'($signed(value[23:0]));
      REG_RECOVERY_JUMP:  rec_jump  = longint'($signed(value[23:0]));
      REG_RECOVERY_RATE:  rec_rate  = longint'(value[16:0]);
      REG_RECOVERY_SENS:  rec_sens  = longint'($signed(value[23:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_config(longint k, longint vr, longint vt, longint vpk,
                              longint c, longint d, longint a, longint b);
    write_reg(REG_QUAD_GAIN, k);
    write_reg(REG_REST_VOLTAGE, vr);
    write_reg(REG_THRESH_VOLTAGE, vt);
    write_reg(REG_PEAK_VOLTAGE, vpk);
    write_reg(REG_RESET_VOLTAGE, c);
    write_reg(REG_RECOVERY_JUMP, d);
    write_reg(REG_RECOVERY_RATE, a);
    write_reg(REG_RECOVERY_SENS, b);
  endtask

  task automatic send_item(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] i_ext,
                           logic signed [DATA_W-1:0] i_syn);
    int gap;
    gap = draw_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      update_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    update_req.valid        <= 1'b1;
    update_req.neuron_index <= idx;
    update_req.ext_current  <= i_ext;
    update_req.syn_current  <= i_syn;
    do @(posedge clk); while (update_req.ready !== 1'b1);
    expected_updates.push_back(euler_step(idx, i_ext, i_syn));
  endtask

  task automatic wait_results_done(int slack);
    @(negedge clk);
    update_req.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (slack) @(posedge clk);
  endtask

  // Most items drive a few neurons with plausible currents so that they climb to a
  // spike; the rest hit random neurons with full-range or near-zero currents.
  task automatic random_items(int count);
    int                       pick;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] i_ext, i_syn;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        idx   = IDX_W'($urandom_range(0, 7) * 17);
        i_ext = $urandom_range(0, 1000 * MV);
        i_syn = int'($urandom_range(0, 60 * MV)) - 30 * MV;
      end else if (pick < 85) begin
        idx   = IDX_W'($urandom_range(0, 127));
        i_ext = $urandom;
        i_syn = $urandom;
      end else begin
        idx   = IDX_W'($urandom_range(0, 127));
        i_ext = int'($urandom_range(0, 2 * MV)) - MV;
        i_syn = int'($urandom_range(0, 2 * MV)) - MV;
      end
      send_item(idx, i_ext, i_syn);
    end
  endtask

  task automatic test_state_extremes();
    send_item(0, 0, 0);
    send_item(0, 0, 0);
    // A huge drive lifts the neuron past the peak; the next two items show the spike
    // and the step after it.
    send_item(127, I_MAX, I_MAX);
    send_item(127, 0, 0);
    send_item(127, 0, 0);
    send_item(1, I_MIN, I_MIN);
    send_item(1, I_MIN, I_MIN);
    send_item(1, 0, 0);
    send_item(2, I_MAX, I_MIN);
    send_item(3, 32'sh0000_FFFF, 32'shFFFF_0001);
    send_item(64, 32'sh5555_5555, 32'shAAAA_AAAA);
    send_item(63, 32'shAAAA_AAAA, 32'sh5555_5555);
    repeat (6) send_item(5, 200 * MV, 0);
  endtask

  task automatic test_random_default();
    random_items(150);
    wait_results_done(0);
    random_items(150);
  endtask

  task automatic test_regular_spiking();
    wait_results_done(0);
    apply_config(45875, -60 * MV, -40 * MV, 35 * MV, -50 * MV, 100 * MV, 1966, -2 * MV);
    random_items(150);
  endtask

  task automatic test_saturation_limits();
    wait_results_done(0);
    apply_config(8388607, 8388607, -8388608, 8388607, 8388607, 8388607, 65536, 8388607);
    repeat (3) send_item(10, I_MAX, I_MAX);
    repeat (3) send_item(11, I_MIN, I_MIN);
    random_items(100);
  endtask

  task automatic test_floor_limits();
    wait_results_done(0);
    apply_config(0, -8388608, 8388607, -8388608, -8388608, -8388608, 0, -8388608);
    random_items(100);
  endtask

  task automatic test_defaults_restored();
    wait_results_done(0);
    apply_config(QUAD_GAIN_RST, REST_VOLT_RST, THRESH_VOLT_RST, PEAK_VOLT_RST,
                 RESET_VOLT_RST, REC_JUMP_RST, REC_RATE_RST, REC_SENS_RST);
    random_items(400);
  endtask

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random back-pressure, each result checked against the oldest prediction.
  initial begin
    int             stall;
    neuron_update_t want;
    update_rsp.ready = 1'b0;
    forever begin
      stall = draw_gap(recv_calm);
      @(negedge clk);
      if (stall > 0) begin
        update_rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      update_rsp.ready <= 1'b1;
      do @(posedge clk); while (update_rsp.valid !== 1'b1);
      if (expected_updates.size() == 0) begin
        $display("%0t: result for neuron %0d with no item pending", $time,
                 update_rsp.out_index);
        mismatch_count++;
      end else begin
        want = expected_updates.pop_front();
        compare_field("out_index", want.index, update_rsp.out_index);
        compare_field("spiked", want.spiked, update_rsp.spiked);
        compare_field("new_voltage", want.voltage, update_rsp.new_voltage);
        compare_field("new_recovery", want.recovery, update_rsp.new_recovery);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    cfg_wr_en               = 1'b0;
    cfg_index               = '0;
    cfg_wdata               = '0;
    update_req.valid        = 1'b0;
    update_req.neuron_index = '0;
    update_req.ext_current  = '0;
    update_req.syn_current  = '0;
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_state_extremes();
    test_random_default();
    test_regular_spiking();
    test_saturation_limits();
    test_floor_limits();
    test_defaults_restored();

    wait_results_done(20);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
